// File: sv/rmo_pkg.sv
package rmo_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_LENGTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_GAIN       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK_GAIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING_GAIN = 3'd3;

   localparam int DELAY_W = 15;
   localparam int GAIN_W  = 16;

   localparam logic [DELAY_W-1:0] DELAY_LENGTH_RST   = 15'd8820;
   localparam logic [GAIN_W-1:0]  MIX_GAIN_RST       = 16'd13107;
   localparam logic [GAIN_W-1:0]  FEEDBACK_GAIN_RST  = 16'd19661;
   localparam logic [GAIN_W-1:0]  SMOOTHING_GAIN_RST = 16'd6554;

   // Word fields
   localparam int CARRIER_W   = 29;
   localparam int MODULATOR_W = 22;
   localparam int SAMPLE_W    = 16;
   localparam int STEP_W      = 32;
   localparam int SINE_MAG_W  = 15;

   // Shared multiplier operands
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Multiplier operand selects
   localparam logic [2:0] MUL_SMC  = 3'd0;
   localparam logic [2:0] MUL_SMM  = 3'd1;
   localparam logic [2:0] MUL_PROD = 3'd2;
   localparam logic [2:0] MUL_FB   = 3'd3;
   localparam logic [2:0] MUL_MIX  = 3'd4;

   // Controller to datapath
   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [2:0] mul_sel;
      logic       upd_c;
      logic       upd_m;
      logic       advance;
      logic       rom_c;
      logic       rom_m;
      logic       mem_rd;
      logic       round_p;
      logic       wr_echo;
      logic       out_load;
      logic       clear_step;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic block_start;
      logic clear_last;
   } sts_type;

   // Quarter-wave table build, elaboration only
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [8] = '{64'd1, 64'd6, 64'd20, 64'd42,
                                              64'd72, 64'd110, 64'd156, 64'd210};

   function automatic logic [SINE_MAG_W-1:0] qsine_entry(input int unsigned idx,
                                                         input int unsigned tb);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] r;
      x    = (64'(2 * idx + 1) * HALF_PI_Q30) >> (tb + 1);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int k = 1; k < 8; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k];
         if ((k & 1) != 0) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 64'sd16384) >>> 15;
      if (r > 64'sd32767) begin
         r = 64'sd32767;
      end
      return r[SINE_MAG_W-1:0];
   endfunction

   // Clamp an 18-bit sum to signed 16 bits
   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [17:0] v);
      if (v > 18'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         return 16'sh8000;
      end else begin
         return v[SAMPLE_W-1:0];
      end
   endfunction

endpackage

// File: sv/rmo_sine_rom.sv
module rmo_sine_rom #(
   parameter int TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [TABLE_BITS-1:0]               rd_addr,
   output logic [rmo_pkg::SINE_MAG_W-1:0]      rd_data
);

   localparam int DEPTH = 1 << TABLE_BITS;

   logic [rmo_pkg::SINE_MAG_W-1:0] rom_table [DEPTH];
   logic [rmo_pkg::SINE_MAG_W-1:0] rom_data_ff;

   // First quarter of the sine, built at elaboration
   for (genvar g = 0; g < DEPTH; g++) begin : g_rom
      localparam logic [rmo_pkg::SINE_MAG_W-1:0] ENTRY =
         rmo_pkg::qsine_entry(g, TABLE_BITS);
      assign rom_table[g] = ENTRY;
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rom_data_ff <= rom_table[rd_addr];
      end
   end

   assign rd_data = rom_data_ff;

endmodule

// File: sv/rmo_datapath.sv
module rmo_datapath #(
   parameter int MAX_DELAY       = 16384,
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rmo_pkg::cmd_type                       cmd,
   output rmo_pkg::sts_type                       sts,
   input  logic [rmo_pkg::CARRIER_W-1:0]          req_carrier_tuning,
   input  logic [rmo_pkg::MODULATOR_W-1:0]        req_modulator_tuning,
   input  logic                                   req_block_start,
   input  logic                                   csr_write,
   input  logic [rmo_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [rmo_pkg::CSR_DATA_W-1:0]         csr_data,
   output logic signed [rmo_pkg::SAMPLE_W-1:0]    rsp_sample_out
);

   localparam int AW    = $clog2(MAX_DELAY);
   localparam int LEN_W = $clog2(MAX_DELAY + 1);
   localparam int CMP_W = (LEN_W > rmo_pkg::DELAY_W) ? LEN_W : rmo_pkg::DELAY_W;
   localparam int IDX_W = SINE_TABLE_BITS + 2;

   // Configuration registers
   logic [rmo_pkg::DELAY_W-1:0] delay_length_ff;
   logic [rmo_pkg::GAIN_W-1:0]  mix_gain_ff;
   logic [rmo_pkg::GAIN_W-1:0]  feedback_gain_ff;
   logic [rmo_pkg::GAIN_W-1:0]  smoothing_gain_ff;

   // Oscillator state
   logic [rmo_pkg::STEP_W-1:0]  carrier_step_ff;
   logic [rmo_pkg::STEP_W-1:0]  modulator_step_ff;
   logic [PHASE_BITS-1:0]       carrier_phase_ff;
   logic [PHASE_BITS-1:0]       modulator_phase_ff;
   logic [AW-1:0]               write_pointer_ff;

   // Word holding and working registers
   logic [rmo_pkg::CARRIER_W-1:0]       carrier_tuning_ff;
   logic [rmo_pkg::MODULATOR_W-1:0]     modulator_tuning_ff;
   logic                                block_start_ff;
   logic signed [rmo_pkg::MUL_P_W-1:0]  prod_ff;
   logic signed [rmo_pkg::SAMPLE_W-1:0] s1_ff;
   logic signed [rmo_pkg::SAMPLE_W-1:0] p_ff;
   logic signed [rmo_pkg::SAMPLE_W-1:0] echo_ff;
   logic signed [rmo_pkg::SAMPLE_W-1:0] sample_ff;
   logic                                neg_ff;

   // Echo ring store
   logic signed [rmo_pkg::SAMPLE_W-1:0] echo_mem [MAX_DELAY];

   // Combinational
   logic [CMP_W-1:0]                    len_wide;
   logic [LEN_W-1:0]                    len;
   logic [AW-1:0]                       wp_fix;
   logic [LEN_W-1:0]                    wp_next_wide;
   logic [AW-1:0]                       wp_next;
   logic signed [32:0]                  d_c;
   logic signed [32:0]                  d_m;
   logic signed [rmo_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [rmo_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [rmo_pkg::MUL_P_W-1:0]  mul_p;
   logic [IDX_W-1:0]                    c_idx;
   logic [IDX_W-1:0]                    m_idx;
   logic [IDX_W-1:0]                    sel_idx;
   logic [SINE_TABLE_BITS-1:0]          rom_addr;
   logic [rmo_pkg::SINE_MAG_W-1:0]      rom_data;
   logic signed [rmo_pkg::SAMPLE_W-1:0] sine_val;
   logic signed [rmo_pkg::MUL_P_W-1:0]  p_rnd;
   logic signed [rmo_pkg::MUL_P_W-1:0]  g_rnd;
   logic signed [16:0]                  g_term;
   logic signed [17:0]                  g_sum;
   logic signed [rmo_pkg::SAMPLE_W-1:0] g_sat;

   // Effective ring length
   always_comb begin
      len_wide = CMP_W'(delay_length_ff);
      if (len_wide < CMP_W'(2)) begin
         len_wide = CMP_W'(2);
      end else if (len_wide > CMP_W'(MAX_DELAY)) begin
         len_wide = CMP_W'(MAX_DELAY);
      end
      len = LEN_W'(len_wide);
   end

   // Pointer restart and ring successor
   assign wp_fix       = (LEN_W'(write_pointer_ff) >= len) ? '0 : write_pointer_ff;
   assign wp_next_wide = LEN_W'(write_pointer_ff) + LEN_W'(1);
   assign wp_next      = (wp_next_wide >= len) ? '0 : wp_next_wide[AW-1:0];

   // Smoothing errors
   assign d_c = signed'(33'(carrier_tuning_ff)) - signed'(33'(carrier_step_ff));
   assign d_m = signed'(33'(modulator_tuning_ff)) - signed'(33'(modulator_step_ff));

   // Shared multiplier operand select
   always_comb begin
      unique case (cmd.mul_sel)
         rmo_pkg::MUL_SMC: begin
            mul_a = rmo_pkg::MUL_A_W'(d_c);
            mul_b = signed'({1'b0, smoothing_gain_ff});
         end
         rmo_pkg::MUL_SMM: begin
            mul_a = rmo_pkg::MUL_A_W'(d_m);
            mul_b = signed'({1'b0, smoothing_gain_ff});
         end
         rmo_pkg::MUL_PROD: begin
            mul_a = rmo_pkg::MUL_A_W'(s1_ff);
            mul_b = rmo_pkg::MUL_B_W'(sine_val);
         end
         rmo_pkg::MUL_FB: begin
            mul_a = rmo_pkg::MUL_A_W'(echo_ff);
            mul_b = signed'({1'b0, feedback_gain_ff});
         end
         rmo_pkg::MUL_MIX: begin
            mul_a = rmo_pkg::MUL_A_W'(echo_ff);
            mul_b = signed'({1'b0, mix_gain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Sine lookup: quadrant picks mirror and sign
   assign c_idx    = carrier_phase_ff[PHASE_BITS-1 -: IDX_W];
   assign m_idx    = modulator_phase_ff[PHASE_BITS-1 -: IDX_W];
   assign sel_idx  = cmd.rom_m ? m_idx : c_idx;
   assign rom_addr = sel_idx[SINE_TABLE_BITS] ? ~sel_idx[SINE_TABLE_BITS-1:0]
                                              : sel_idx[SINE_TABLE_BITS-1:0];
   assign sine_val = neg_ff ? -signed'({1'b0, rom_data}) : signed'({1'b0, rom_data});

   rmo_sine_rom #(
      .TABLE_BITS (SINE_TABLE_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (cmd.rom_c | cmd.rom_m),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   // Rounding of product and gain terms
   assign p_rnd  = prod_ff + rmo_pkg::MUL_P_W'(16384);
   assign g_rnd  = prod_ff + rmo_pkg::MUL_P_W'(32768);
   assign g_term = g_rnd[32:16];
   assign g_sum  = 18'(p_ff) + 18'(g_term);
   assign g_sat  = rmo_pkg::sat16(g_sum);

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_length_ff    <= rmo_pkg::DELAY_LENGTH_RST;
         mix_gain_ff        <= rmo_pkg::MIX_GAIN_RST;
         feedback_gain_ff   <= rmo_pkg::FEEDBACK_GAIN_RST;
         smoothing_gain_ff  <= rmo_pkg::SMOOTHING_GAIN_RST;
         carrier_step_ff    <= '0;
         modulator_step_ff  <= '0;
         carrier_phase_ff   <= '0;
         modulator_phase_ff <= '0;
         write_pointer_ff   <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == rmo_pkg::CSR_DELAY_LENGTH) begin
               delay_length_ff <= csr_data[rmo_pkg::DELAY_W-1:0];
            end
            if (csr_index == rmo_pkg::CSR_MIX_GAIN) begin
               mix_gain_ff <= csr_data;
            end
            if (csr_index == rmo_pkg::CSR_FEEDBACK_GAIN) begin
               feedback_gain_ff <= csr_data;
            end
            if (csr_index == rmo_pkg::CSR_SMOOTHING_GAIN) begin
               smoothing_gain_ff <= csr_data;
            end
         end
         if (cmd.upd_c) begin
            carrier_step_ff <= carrier_step_ff + prod_ff[47:16];
         end
         if (cmd.upd_m) begin
            modulator_step_ff <= modulator_step_ff + prod_ff[47:16];
         end
         if (cmd.advance) begin
            carrier_phase_ff   <= carrier_phase_ff + carrier_step_ff[PHASE_BITS-1:0];
            modulator_phase_ff <= modulator_phase_ff + modulator_step_ff[PHASE_BITS-1:0];
            write_pointer_ff   <= wp_fix;
         end
         if (cmd.wr_echo) begin
            write_pointer_ff <= wp_next;
         end
         if (cmd.clear_step) begin
            write_pointer_ff <= sts.clear_last ? '0 : write_pointer_ff + AW'(1);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         carrier_tuning_ff   <= req_carrier_tuning;
         modulator_tuning_ff <= req_modulator_tuning;
         block_start_ff      <= req_block_start;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.rom_c) begin
         neg_ff <= c_idx[IDX_W-1];
      end
      if (cmd.rom_m) begin
         neg_ff <= m_idx[IDX_W-1];
         s1_ff  <= sine_val;
      end
      if (cmd.round_p) begin
         p_ff <= p_rnd[30:15];
      end
      if (cmd.out_load) begin
         sample_ff <= g_sat;
      end
   end

   // Echo store write: clearing pass or feedback word
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         echo_mem[write_pointer_ff] <= '0;
      end else if (cmd.wr_echo) begin
         echo_mem[write_pointer_ff] <= g_sat;
      end
   end

   // Echo store read, one entry past the write pointer
   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         echo_ff <= echo_mem[wp_next];
      end
   end

   assign sts.block_start = block_start_ff;
   assign sts.clear_last  = (write_pointer_ff == AW'(MAX_DELAY - 1));
   assign rsp_sample_out  = sample_ff;

endmodule

// File: sv/rmo_ctrl.sv
module rmo_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  rmo_pkg::sts_type sts,
   output rmo_pkg::cmd_type cmd
);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_SMC   = 4'd2;
   localparam logic [3:0] ST_SMCU  = 4'd3;
   localparam logic [3:0] ST_SMMU  = 4'd4;
   localparam logic [3:0] ST_ADV   = 4'd5;
   localparam logic [3:0] ST_ROMC  = 4'd6;
   localparam logic [3:0] ST_ROMM  = 4'd7;
   localparam logic [3:0] ST_PROD  = 4'd8;
   localparam logic [3:0] ST_FB    = 4'd9;
   localparam logic [3:0] ST_WR    = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SMC;
            end
         end
         ST_SMC: begin
            if (sts.block_start) begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = rmo_pkg::MUL_SMC;
               state_in    = ST_SMCU;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_SMCU: begin
            cmd.upd_c   = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rmo_pkg::MUL_SMM;
            state_in    = ST_SMMU;
         end
         ST_SMMU: begin
            cmd.upd_m = 1'b1;
            state_in  = ST_ADV;
         end
         ST_ADV: begin
            cmd.advance = 1'b1;
            state_in    = ST_ROMC;
         end
         ST_ROMC: begin
            cmd.rom_c = 1'b1;
            state_in  = ST_ROMM;
         end
         ST_ROMM: begin
            cmd.rom_m = 1'b1;
            state_in  = ST_PROD;
         end
         ST_PROD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rmo_pkg::MUL_PROD;
            cmd.mem_rd  = 1'b1;
            state_in    = ST_FB;
         end
         ST_FB: begin
            cmd.round_p = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rmo_pkg::MUL_FB;
            state_in    = ST_WR;
         end
         ST_WR: begin
            cmd.wr_echo = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rmo_pkg::MUL_MIX;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output word valid
   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/ring_mod_oscillator_with_echo_unit.sv
// Channel   Ports                                                 Dir  Handshake
// req       req_carrier_tuning, req_modulator_tuning,             in   req_valid / req_stall
//           req_block_start
// rsp       rsp_sample_out                                        out  rsp_valid / rsp_stall
// csr       csr_index, csr_data                                   in   csr_write
//
// A word is accepted only in idle, after the previous word has left its sequence;
// the sequence steps share one 34x17 multiplier, one sine ROM port and one
// echo store port, used in turn by the controller; block_start adds the smoothing steps.
// After reset the echo store is cleared, one entry a cycle, all MAX_DELAY entries with
// req_stall high. A stalled result holds in the output register while the next
// word is taken; the sequence waits only at its last step if that register is full.
module ring_mod_oscillator_with_echo_unit #(
   parameter int MAX_DELAY       = 16384,
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rmo_pkg::CARRIER_W-1:0]       req_carrier_tuning,
   input  logic [rmo_pkg::MODULATOR_W-1:0]     req_modulator_tuning,
   input  logic                                req_block_start,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rmo_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                csr_write,
   input  logic [rmo_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rmo_pkg::CSR_DATA_W-1:0]      csr_data
);

   rmo_pkg::cmd_type cmd;
   rmo_pkg::sts_type sts;

   rmo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rmo_datapath #(
      .MAX_DELAY       (MAX_DELAY),
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_carrier_tuning   (req_carrier_tuning),
      .req_modulator_tuning (req_modulator_tuning),
      .req_block_start      (req_block_start),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_sample_out       (rsp_sample_out)
   );

`ifndef SYNTHESIS
   // after a word is taken the block is busy on it
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("word accepted while previous one in progress");

   // a new result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && rsp_stall))
      else $error("output register overwritten while stalled");

   // echo write and clearing pass never overlap
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !cmd.wr_echo && req_stall)
      else $error("echo store written during clearing pass");
`endif

endmodule

// File: tb/testbench.sv
// Tracks the block's expected samples: a bit-exact copy of the oscillator,
// ring modulator and echo, advanced once per accepted request word.
class ring_mod_scoreboard;
   localparam int RING_DEPTH = 16384;
   localparam int TABLE_BITS = 10;
   localparam int TABLE_SIZE = 1 << TABLE_BITS;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int MAX_REPORTS = 10;

   // Registers as last written
   logic [rmo_pkg::DELAY_W-1:0] delay_length;
   logic [rmo_pkg::GAIN_W-1:0]  mix_gain;
   logic [rmo_pkg::GAIN_W-1:0]  feedback_gain;
   logic [rmo_pkg::GAIN_W-1:0]  smoothing_gain;

   // Oscillator and echo state
   logic [31:0]        carrier_phase;
   logic [31:0]        carrier_step;
   logic [31:0]        modulator_phase;
   logic [31:0]        modulator_step;
   logic signed [15:0] echo_ring [RING_DEPTH];
   int unsigned        write_pos;
   logic [14:0]        quarter_sine [TABLE_SIZE];

   logic signed [15:0] expected_samples [$];
   int                 failures;
   int                 reported;

   function new();
      delay_length    = rmo_pkg::DELAY_LENGTH_RST;
      mix_gain        = rmo_pkg::MIX_GAIN_RST;
      feedback_gain   = rmo_pkg::FEEDBACK_GAIN_RST;
      smoothing_gain  = rmo_pkg::SMOOTHING_GAIN_RST;
      carrier_phase   = '0;
      carrier_step    = '0;
      modulator_phase = '0;
      modulator_step  = '0;
      write_pos       = 0;
      failures        = 0;
      reported        = 0;
      foreach (echo_ring[i]) echo_ring[i] = '0;
      build_quarter_sine();
   endfunction

   // Quarter-wave table: Taylor series in Q30, rounded half up to Q15
   function void build_quarter_sine();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      longint          r;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         x    = (longint'(2 * i + 1) * HALF_PI_Q30) / (2 * TABLE_SIZE);
         x2   = (x * x) >> 30;
         term = x;
         acc  = x;
         for (int k = 1; k < 8; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) acc = 0;
         r = (acc + 16384) >>> 15;
         if (r > 32767) r = 32767;
         quarter_sine[i] = r[14:0];
      end
   endfunction

   function logic signed [15:0] clamp_q15(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function int sine_of(logic [31:0] ph);
      logic [11:0] idx;
      int          v;
      idx = ph[31:20];
      v = int'(idx[10] ? quarter_sine[TABLE_SIZE - 1 - idx[9:0]] : quarter_sine[idx[9:0]]);
      return idx[11] ? -v : v;
   endfunction

   // One smoothing step: floor of error times gain over 2^16, modulo 2^32
   function logic [31:0] smooth_step(logic [31:0] cur, logic [31:0] target);
      longint c;
      longint t;
      longint g;
      longint delta;
      longint sum;
      c = longint'(cur);
      t = longint'(target);
      g = longint'(smoothing_gain);
      delta = ((t - c) * g) >>> 16;
      sum = c + delta;
      return sum[31:0];
   endfunction

   function void write_reg(logic [rmo_pkg::CSR_INDEX_W-1:0] index,
                           logic [rmo_pkg::CSR_DATA_W-1:0] data);
      case (index)
         rmo_pkg::CSR_DELAY_LENGTH:   delay_length   = data[rmo_pkg::DELAY_W-1:0];
         rmo_pkg::CSR_MIX_GAIN:       mix_gain       = data;
         rmo_pkg::CSR_FEEDBACK_GAIN:  feedback_gain  = data;
         rmo_pkg::CSR_SMOOTHING_GAIN: smoothing_gain = data;
         default: ;
      endcase
   endfunction

   // Advance one sample tick and queue the sample it yields
   function void note_word(logic [rmo_pkg::CARRIER_W-1:0] ct,
                           logic [rmo_pkg::MODULATOR_W-1:0] mt, logic bs);
      int unsigned ring_len;
      int unsigned read_pos;
      longint      prod;
      longint      echo;
      longint      fb;
      longint      mix;
      if (bs) begin
         carrier_step   = smooth_step(carrier_step, 32'(ct));
         modulator_step = smooth_step(modulator_step, 32'(mt));
      end
      carrier_phase   = carrier_phase + carrier_step;
      modulator_phase = modulator_phase + modulator_step;

      prod = longint'(sine_of(carrier_phase));
      prod = (prod * longint'(sine_of(modulator_phase)) + 16384) >>> 15;

      // ring length limited to 2..depth; a stale pointer restarts at zero
      ring_len = 32'(delay_length);
      if (ring_len < 2) ring_len = 2;
      if (ring_len > RING_DEPTH) ring_len = RING_DEPTH;
      if (write_pos >= ring_len) write_pos = 0;
      read_pos = write_pos + 1;
      if (read_pos >= ring_len) read_pos = 0;

      echo = longint'(echo_ring[read_pos]);
      fb   = longint'(feedback_gain);
      mix  = longint'(mix_gain);
      echo_ring[write_pos] = clamp_q15(prod + ((fb * echo + 32768) >>> 16));
      write_pos++;
      if (write_pos >= ring_len) write_pos = 0;
      expected_samples.insert(expected_samples.size(),
                              clamp_q15(prod + ((mix * echo + 32768) >>> 16)));
   endfunction

   function void check_sample(logic signed [15:0] actual);
      logic signed [15:0] want;
      if (expected_samples.size() == 0) begin
         failures++;
         if (reported < MAX_REPORTS) begin
            $display("unexpected sample %0d with none pending", actual);
            reported++;
         end
         return;
      end
      want = expected_samples.pop_front();
      if (actual !== want) begin
         failures++;
         if (reported < MAX_REPORTS) begin
            $display("sample mismatch: expected %0d, got %0d", want, actual);
            reported++;
         end
      end
   endfunction

   function int pending();
      return expected_samples.size();
   endfunction
endclass

module testbench;
   localparam int  WATCHDOG_LIMIT = 70000;  // covers the echo store clear after reset
   localparam int  SETTLE_CYCLES  = 16;
   localparam int  PHASES         = 14;
   localparam logic [rmo_pkg::CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = 3'd4;
   localparam logic [rmo_pkg::CSR_INDEX_W-1:0] CSR_LAST_UNUSED  = 3'd7;
   localparam logic [rmo_pkg::GAIN_W-1:0]      GAIN_MAX         = 16'hFFFF;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [rmo_pkg::CARRIER_W-1:0]       req_carrier_tuning = '0;
   logic [rmo_pkg::MODULATOR_W-1:0]     req_modulator_tuning = '0;
   logic                                req_block_start = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [rmo_pkg::SAMPLE_W-1:0] rsp_sample_out;
   logic                                csr_write = 1'b0;
   logic [rmo_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [rmo_pkg::CSR_DATA_W-1:0]      csr_data = '0;

   ring_mod_scoreboard sample_board = new();

   int quiet_cycles = 0;
   int stall_mode = 0;
   int stall_window = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ring_mod_oscillator_with_echo_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_carrier_tuning   (req_carrier_tuning),
      .req_modulator_tuning (req_modulator_tuning),
      .req_block_start      (req_block_start),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_sample_out       (rsp_sample_out),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // Receiver stall: stall density changes at the end of each random window, zero to 3/4
   always @(posedge clock) begin
      if (stall_window == 0) begin
         stall_mode   <= $urandom_range(3, 0);
         stall_window <= $urandom_range(64, 8);
      end else begin
         stall_window <= stall_window - 1;
      end
      rsp_stall <= ($urandom_range(3, 0) < stall_mode);
   end

   // Result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         sample_board.check_sample(rsp_sample_out);
      end
   end

   // Watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one word and hold it until taken
   task automatic send_word(logic [rmo_pkg::CARRIER_W-1:0] ct,
                            logic [rmo_pkg::MODULATOR_W-1:0] mt, logic bs);
      req_valid            <= 1'b1;
      req_carrier_tuning   <= ct;
      req_modulator_tuning <= mt;
      req_block_start      <= bs;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sample_board.note_word(ct, mt, bs);
   endtask

   // Random words in bursts with random gaps; tunings matter on block starts
   task automatic send_stream(int count);
      logic [rmo_pkg::CARRIER_W-1:0]   ct;
      logic [rmo_pkg::MODULATOR_W-1:0] mt;
      logic                            bs;
      int                              burst_left;
      int                              gap;
      burst_left = $urandom_range(24, 1);
      for (int n = 0; n < count; n++) begin
         bs = ($urandom_range(3, 0) == 0);
         case ($urandom_range(3, 0))
            0, 1: begin
               ct = rmo_pkg::CARRIER_W'($urandom);
               mt = rmo_pkg::MODULATOR_W'($urandom);
            end
            2: begin
               ct = rmo_pkg::CARRIER_W'($urandom_range(1 << 20, 0));
               mt = rmo_pkg::MODULATOR_W'($urandom_range(1 << 16, 0));
            end
            default: begin
               ct = $urandom_range(1, 0) ? '1 : '0;
               mt = $urandom_range(1, 0) ? '1 : '0;
            end
         endcase
         send_word(ct, mt, bs);
         burst_left--;
         if (burst_left == 0) begin
            gap = $urandom_range(8, 0);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(3, 0) == 0) ? 200 : $urandom_range(24, 1);
         end
      end
      req_valid <= 1'b0;
   endtask

   // Wait for every expected sample, then let the pipeline drain
   task automatic settle();
      while (sample_board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [rmo_pkg::CSR_INDEX_W-1:0] index,
                            logic [rmo_pkg::CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      sample_board.write_reg(index, data);
   endtask

   // All four registers plus one write to an index that does not exist
   task automatic configure(logic [rmo_pkg::DELAY_W-1:0] delay,
                            logic [rmo_pkg::GAIN_W-1:0] mix,
                            logic [rmo_pkg::GAIN_W-1:0] fb,
                            logic [rmo_pkg::GAIN_W-1:0] smooth);
      write_reg(rmo_pkg::CSR_DELAY_LENGTH, {1'($urandom), delay});
      write_reg(rmo_pkg::CSR_MIX_GAIN, mix);
      write_reg(rmo_pkg::CSR_FEEDBACK_GAIN, fb);
      write_reg(rmo_pkg::CSR_SMOOTHING_GAIN, smooth);
      write_reg(rmo_pkg::CSR_INDEX_W'($urandom_range(CSR_LAST_UNUSED, CSR_FIRST_UNUSED)),
                rmo_pkg::CSR_DATA_W'($urandom));
      csr_write <= 1'b0;
   endtask

   function automatic logic [rmo_pkg::GAIN_W-1:0] pick_gain();
      case ($urandom_range(3, 0))
         0:       return '0;
         1:       return GAIN_MAX;
         default: return rmo_pkg::GAIN_W'($urandom);
      endcase
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Field extremes and bit patterns under the reset settings
      send_word('0, '0, 1'b1);
      send_word('1, '1, 1'b1);
      send_word('1, '1, 1'b0);
      send_word('1, '0, 1'b1);
      send_word('0, '1, 1'b1);
      send_word(29'h0AAA_AAAA, 22'h15_5555, 1'b1);
      send_word(29'h1555_5555, 22'h2A_AAAA, 1'b1);
      send_word('0, '0, 1'b0);
      send_word(29'h1000_0000, 22'h20_0000, 1'b1);
      send_word(29'h0000_0001, 22'h00_0001, 1'b1);
      send_word('1, '1, 1'b1);
      send_word('1, '1, 1'b1);
      send_word('0, '0, 1'b0);
      send_word('0, '0, 1'b1);
      send_word('0, '0, 1'b1);
      send_word('1, '1, 1'b0);
      req_valid <= 1'b0;

      for (int phase = 1; phase <= PHASES; phase++) begin
         settle();
         case (phase)
            1: configure(15'd2, GAIN_MAX, GAIN_MAX, GAIN_MAX);      // shortest ring, full gains
            2: configure(15'd0, '0, '0, '0);                        // length below 2
            3: configure(15'd1, 16'h8000, GAIN_MAX, GAIN_MAX);
            4: configure(15'd40, pick_gain(), pick_gain(), GAIN_MAX);
            5: configure(15'd3, pick_gain(), pick_gain(), pick_gain()); // pointer past new end
            6: configure(15'h7FFF, GAIN_MAX, GAIN_MAX, pick_gain()); // length above depth
            7: configure(15'd16384, pick_gain(), pick_gain(), pick_gain());
            8: configure(15'd16385, pick_gain(), pick_gain(), pick_gain());
            default: configure(($urandom_range(3, 0) == 0) ? 15'($urandom)
                                                            : 15'($urandom_range(64, 2)),
                               pick_gain(), pick_gain(), pick_gain());
         endcase
         send_stream(phase == 4 ? 37 : $urandom_range(50, 34));
      end

      settle();
      if (sample_board.failures == 0 && sample_board.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
